FILE: rtl/rsht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsht_pkg
// shared types and constants of the range sample height tracker
// ----------------------------------------------------------------------------
package rsht_pkg;

    localparam int DATA_W   = 16;   // distance and average width
    localparam int STATUS_W = 8;
    localparam int CMD_W    = 2;
    localparam int VAL_W    = 2;
    localparam int HEIGHT_W = 8;
    localparam int CAL_W    = 11;
    localparam int WSIZE_W  = 6;
    localparam int AGE_W    = 17;
    localparam int CFG_A_W  = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // validity codes
    localparam logic [VAL_W-1:0] VAL_INVALID = 2'd0;
    localparam logic [VAL_W-1:0] VAL_VALID   = 2'd1;
    localparam logic [VAL_W-1:0] VAL_STALE   = 2'd2;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_SENSOR_READY = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_MIN_VALID    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_MAX_RANGE    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_CALIBRATION  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_WINDOW_SIZE  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_STALE_TICKS  = 3'd5;

    localparam logic [STATUS_W-1:0] NO_TARGET_LO = 8'd0;
    localparam logic [STATUS_W-1:0] NO_TARGET_HI = 8'd255;
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 8'd200;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [DATA_W-1:0] RECIP_10    = 16'hCCCD;
    localparam int                RECIP_SHIFT = 19;
    localparam int                Q10_W       = 13;

    // divider result
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_div_out;

endpackage

FILE: rtl/range_sample_height_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sample_height_tracker_core
// filters range samples with a moving average and derives a height
// ----------------------------------------------------------------------------
// path: a tick, clear, invalid or dropped sample goes S_IDLE, S_EVAL, S_EMIT to tvalid;
//   a valid sample goes S_IDLE, S_EVAL, S_PUSH, S_DIV (bit-serial divider), S_SCALE,
//   S_HEIGHT, S_EMIT; S_EMIT waits while a held result is not yet taken
// occupancy: the block holds one item at a time and accepts a new one only in S_IDLE
// reset: synchronous active-low; registers return to their reset values,
//   the window is empty and the window slots themselves are not cleared
// ----------------------------------------------------------------------------
module range_sample_height_tracker_core
    import rsht_pkg::*;
#(
    parameter int MAX_WINDOW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CFG_A_W-1:0]  i_cfg_addr,
    input  logic [DATA_W-1:0]   i_cfg_wdata,

    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // status[7:0], range[23:8]
    input  logic [CMD_W-1:0]    s_axis_tuser,   // cmd[1:0]

    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // raw[15:0], average[31:16], height[39:32]
    output logic [VAL_W-1:0]    m_axis_tuser    // validity[1:0]
);

    localparam int SUM_W = $clog2(MAX_WINDOW * 65535 + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int HSUM_W = Q10_W + 2;   // signed calibration plus scaled average

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PUSH,
        S_DIV,
        S_SCALE,
        S_HEIGHT,
        S_EMIT
    } t_state;

    // configuration registers
    logic                 r_sensor_ready;
    logic [DATA_W-1:0]    r_min_mm;
    logic [DATA_W-1:0]    r_max_mm;
    logic [CAL_W-1:0]     r_cal;
    logic [WSIZE_W-1:0]   r_win_size;
    logic [DATA_W-1:0]    r_stale_ticks;

    // tracker state
    t_state               r_state;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_count;
    logic [AGE_W-1:0]     r_age;
    logic [VAL_W-1:0]     r_validity;
    logic [DATA_W-1:0]    r_raw;
    logic [DATA_W-1:0]    r_avg;
    logic [HEIGHT_W-1:0]  r_height;

    // held transaction and working registers
    logic [CMD_W-1:0]     r_cmd;
    logic [STATUS_W-1:0]  r_status;
    logic [DATA_W-1:0]    r_dist;
    logic [DATA_W-1:0]    r_evict;
    logic [PROD_W-1:0]    r_prod;

    // output register
    logic                 r_m_valid;
    logic [39:0]          r_m_data;
    logic [VAL_W-1:0]     r_m_user;

    // combinational
    logic [CNT_W-1:0]     w_eff_win;
    logic [IDX_W-1:0]     w_sel_idx;
    logic                 w_full;
    logic [DATA_W-1:0]    w_raw;
    logic                 w_raw_ok;
    logic [AGE_W-1:0]     w_age_inc;
    logic [SUM_W-1:0]     n_sum;
    logic [CNT_W-1:0]     n_count;
    logic [DATA_W-1:0]    w_tap_or;
    logic [DATA_W-1:0]    w_chain [0:MAX_WINDOW];
    logic [DATA_W-1:0]    w_taps  [0:MAX_WINDOW-1];
    logic [MAX_WINDOW-1:0] w_sel;
    logic                 w_shift;
    logic                 w_div_start;
    t_div_out             w_div;
    logic [Q10_W-1:0]     w_q10;
    logic signed [HSUM_W-1:0] w_hsum;
    logic [HEIGHT_W-1:0]  w_height;

    // window size: zero acts as one, oversize clamps to the chain length
    always_comb begin
        if (r_win_size == '0) begin
            w_eff_win = CNT_W'(1);
        end else if (int'(r_win_size) > MAX_WINDOW) begin
            w_eff_win = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff_win = CNT_W'(r_win_size);
        end
    end

    assign w_sel_idx = IDX_W'(w_eff_win - 1'b1);
    assign w_full    = (r_count >= w_eff_win);

    // status 0 or 255 means no target, reads as zero distance
    assign w_raw = (r_status == NO_TARGET_LO || r_status == NO_TARGET_HI) ? '0 : r_dist;
    assign w_raw_ok = (w_raw != '0) && (w_raw >= r_min_mm) && (w_raw <= r_max_mm);

    // saturating age
    assign w_age_inc = (r_age == '1) ? r_age : r_age + 1'b1;

    // window update: oldest sample leaves once the window is full
    assign n_sum   = r_sum - (w_full ? SUM_W'(r_evict) : '0) + SUM_W'(r_raw);
    assign n_count = w_full ? r_count : r_count + 1'b1;

    // sample chain, newest at cell 0, oldest of a full window at the last used cell
    assign w_shift    = (r_state == S_PUSH);
    assign w_chain[0] = r_raw;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        assign w_sel[k] = (w_sel_idx == IDX_W'(k));
        rsht_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_data  (w_chain[k]),
            .i_sel   (w_sel[k]),
            .o_data  (w_chain[k+1]),
            .o_tap   (w_taps[k])
        );
    end

    // only the selected tap can be non-zero
    always_comb begin
        w_tap_or = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_tap_or = w_tap_or | w_taps[k];
        end
    end

    assign w_div_start = (r_state == S_PUSH);

    rsht_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_res      (w_div)
    );

    // height: calibration plus average in cm, clamped; zero when uncalibrated
    assign w_q10  = r_prod[RECIP_SHIFT +: Q10_W];
    assign w_hsum = HSUM_W'($signed(r_cal)) + $signed({2'b00, w_q10});

    always_comb begin
        if (r_cal == '0) begin
            w_height = '0;
        end else if (w_hsum < 0) begin
            w_height = '0;
        end else if (w_hsum > $signed(HSUM_W'(HEIGHT_LIMIT))) begin
            w_height = HEIGHT_LIMIT;
        end else begin
            w_height = w_hsum[HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_ready <= 1'b0;
            r_min_mm       <= 16'd20;
            r_max_mm       <= 16'd4000;
            r_cal          <= '0;
            r_win_size     <= 6'd5;
            r_stale_ticks  <= 16'd1000;
            r_state        <= S_IDLE;
            r_sum          <= '0;
            r_count        <= '0;
            r_age          <= '0;
            r_validity     <= VAL_INVALID;
            r_raw          <= '0;
            r_avg          <= '0;
            r_height       <= '0;
            r_cmd          <= CMD_SAMPLE;
            r_status       <= '0;
            r_dist         <= '0;
            r_evict        <= '0;
            r_prod         <= '0;
            r_m_valid      <= 1'b0;
            r_m_data       <= '0;
            r_m_user       <= VAL_INVALID;
        end else begin
            // configuration is to be written by the user only while idle, which the block itself does not enforce
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_SENSOR_READY: r_sensor_ready <= i_cfg_wdata[0];
                    REG_MIN_VALID:    r_min_mm       <= i_cfg_wdata;
                    REG_MAX_RANGE:    r_max_mm       <= i_cfg_wdata;
                    REG_CALIBRATION:  r_cal          <= i_cfg_wdata[CAL_W-1:0];
                    REG_WINDOW_SIZE: begin
                        // new size empties the window
                        r_win_size <= i_cfg_wdata[WSIZE_W-1:0];
                        r_sum      <= '0;
                        r_count    <= '0;
                    end
                    REG_STALE_TICKS:  r_stale_ticks  <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // the emit state drives the valid flag itself
            if (m_axis_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= s_axis_tuser;
                        r_status <= s_axis_tdata[7:0];
                        r_dist   <= s_axis_tdata[23:8];
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_evict <= w_tap_or;
                    r_state <= S_EMIT;
                    unique case (r_cmd)
                        CMD_TICK: begin
                            r_age <= w_age_inc;
                            if (r_sensor_ready && (w_age_inc > {1'b0, r_stale_ticks})) begin
                                r_validity <= VAL_STALE;
                            end
                        end
                        CMD_CLEAR: begin
                            r_sum   <= '0;
                            r_count <= '0;
                        end
                        CMD_SAMPLE: begin
                            if (r_sensor_ready) begin
                                r_raw <= w_raw;
                                r_age <= '0;
                                if (w_raw_ok) begin
                                    r_validity <= VAL_VALID;
                                    r_state    <= S_PUSH;
                                end else begin
                                    r_validity <= VAL_INVALID;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (!r_sensor_ready) begin
                        r_validity <= VAL_INVALID;
                    end
                end
                S_PUSH: begin
                    // chain shifts and divider starts on this edge
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_avg   <= w_div.quot;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_prod  <= r_avg * RECIP_10;
                    r_state <= S_HEIGHT;
                end
                S_HEIGHT: begin
                    r_height <= w_height;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_height, r_avg, r_raw};
                        r_m_user  <= r_validity;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTHESIS
    // fill count never passes the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_WINDOW)
        else $error("sample count beyond window length");

    // an accepted transaction is evaluated in the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == S_EVAL)
        else $error("accepted transaction not evaluated");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divider result outside divide phase");

    // a shift always comes with a non-empty window on the next cycle
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift |=> r_count != '0)
        else $error("window empty after push");
`endif

endmodule

FILE: rtl/rsht_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsht_cell
// one slot of the sample window shift chain
// ----------------------------------------------------------------------------
module rsht_cell
    import rsht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_sel,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_tap
);

    logic [DATA_W-1:0] r_sample;

    // window content needs no reset, the fill count guards every read
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_data;
        end
    end

    assign o_data = r_sample;
    assign o_tap  = i_sel ? r_sample : '0;

endmodule

FILE: rtl/rsht_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsht_div
// restoring divider, one quotient bit per cycle, window sum by sample count
// ----------------------------------------------------------------------------
module rsht_div
    import rsht_pkg::*;
#(
    parameter int SUM_W = 21,
    parameter int CNT_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output t_div_out         o_res
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [DATA_W-1:0] r_dq;    // dividend bits out at the top, quotient bits in below

    logic [CNT_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_dq[DATA_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_rem  <= '0;
            r_dvs  <= '0;
            r_dq   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // average fits 16 bits, so the upper sum bits are already below the divisor
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= CNT_W'(i_dividend >> DATA_W);
                r_dvs  <= i_divisor;
                r_dq   <= i_dividend[DATA_W-1:0];
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= CNT_W'(w_trial - {1'b0, r_dvs});
                end else begin
                    r_rem <= w_trial[CNT_W-1:0];
                end
                r_dq   <= {r_dq[DATA_W-2:0], w_fit};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_dq;

endmodule

FILE: test/tb_range_sample_height_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_sample_height_tracker_core
// self-checking bench for the range sample height tracker: a clocked driver
// feeds commands from a queue, a behavioral tracker predicts each reading at
// acceptance, and a clocked monitor compares every result transaction with the
// oldest predicted reading; register settings change only while the block idles
// ----------------------------------------------------------------------------
module tb_range_sample_height_tracker_core;
    import rsht_pkg::*;

    localparam int          WIN_DEPTH = 32;
    localparam int          IDLE_PCT  = 12;
    localparam int unsigned AGE_SAT   = (1 << AGE_W) - 1;
    // tuser code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   range_val;
    } t_command;

    typedef struct packed {
        logic [VAL_W-1:0]    validity;
        logic [DATA_W-1:0]   raw;
        logic [DATA_W-1:0]   avg;
        logic [HEIGHT_W-1:0] height;
    } t_reading;

    // dut ports, the driven inputs known from time zero
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [CFG_A_W-1:0]  i_cfg_addr    = '0;
    logic [DATA_W-1:0]   i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata  = '0;   // status[7:0], range[23:8]
    logic [CMD_W-1:0]    s_axis_tuser  = '0;   // cmd[1:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;         // raw[15:0], average[31:16], height[39:32]
    logic [VAL_W-1:0]    m_axis_tuser;         // validity[1:0]

    // shared bench state
    t_command command_q [$];     // commands not yet offered to the block
    t_reading reading_q [$];     // predicted readings waiting for their transaction
    int       err_count = 0;
    logic     calm      = 1'b0;  // set during a stretch with no idling on either side

    // tracker shadow: register copies
    logic                     cfg_ready;
    logic [DATA_W-1:0]        cfg_min;
    logic [DATA_W-1:0]        cfg_max;
    logic signed [CAL_W-1:0]  cfg_cal;
    logic [WSIZE_W-1:0]       cfg_wsize;
    logic [DATA_W-1:0]        cfg_stale;

    // tracker shadow: filter and held output
    logic [DATA_W-1:0] win_mem [WIN_DEPTH];
    int unsigned       win_sum;
    int unsigned       win_count;
    int unsigned       win_slot;
    int unsigned       age;
    t_reading          held;

    range_sample_height_tracker_core #(
        .MAX_WINDOW (WIN_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void empty_window();
        win_sum   = 0;
        win_count = 0;
        win_slot  = 0;
    endfunction

    // advance the shadow tracker by one command and return the reading it reports
    function automatic t_reading next_reading(input logic [CMD_W-1:0]    cmd,
                                              input logic [STATUS_W-1:0] status,
                                              input logic [DATA_W-1:0]   range_val);
        logic [DATA_W-1:0] raw;
        int unsigned       span;
        int unsigned       slot;
        int                h;
        if (cmd == CMD_TICK) begin
            if (age < AGE_SAT)
                age++;
            // stale is sticky until the next sample or a command while not ready, whatever came before
            if (cfg_ready && age > cfg_stale)
                held.validity = VAL_STALE;
        end else if (cmd == CMD_CLEAR) begin
            empty_window();
        end else if (cmd == CMD_SAMPLE && cfg_ready) begin
            raw      = (status == NO_TARGET_LO || status == NO_TARGET_HI) ? '0 : range_val;
            held.raw = raw;
            age      = 0;
            if (raw == 0 || raw < cfg_min || raw > cfg_max) begin
                // average and height keep their last values
                held.validity = VAL_INVALID;
            end else begin
                held.validity = VAL_VALID;
                // window size 0 acts as 1, anything above the depth as the depth
                span = (cfg_wsize == 0) ? 1 : (cfg_wsize > WIN_DEPTH) ? WIN_DEPTH : cfg_wsize;
                slot = win_slot % span;
                if (win_count >= span)
                    win_sum -= win_mem[slot];
                else
                    win_count++;
                win_mem[slot] = raw;
                win_sum += raw;
                win_slot = (slot + 1 >= span) ? 0 : slot + 1;
                held.avg = DATA_W'(win_sum / win_count);
                if (cfg_cal == 0) begin
                    held.height = '0;
                end else begin
                    h = int'(cfg_cal) + int'(held.avg / 10);
                    if (h < 0)
                        h = 0;
                    if (h > HEIGHT_LIMIT)
                        h = HEIGHT_LIMIT;
                    held.height = h[HEIGHT_W-1:0];
                end
            end
        end
        if (!cfg_ready)
            held.validity = VAL_INVALID;
        return held;
    endfunction

    // driver: offers queued commands, predicts each one the moment it is accepted
    always @(posedge i_clk) begin : feed_proc
        t_command nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                reading_q.push_back(next_reading(s_axis_tuser, s_axis_tdata[7:0],
                                                 s_axis_tdata[23:8]));
            // load a new command only when the current one is gone
            if (!s_axis_tvalid || s_axis_tready) begin
                if (command_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = command_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.cmd;
                    s_axis_tdata  <= {nxt.range_val, nxt.status};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, compares each result transaction
    always @(posedge i_clk) begin : check_proc
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                       m_axis_tdata[39:32]};
                if (reading_q.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected result: actual val=%0d raw=%0d avg=%0d h=%0d",
                             $time, got.validity, got.raw, got.avg, got.height);
                end else begin
                    want = reading_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        $display({"%0t mismatch: expected val=%0d raw=%0d avg=%0d h=%0d",
                                  " actual val=%0d raw=%0d avg=%0d h=%0d"}, $time,
                                 want.validity, want.raw, want.avg, want.height,
                                 got.validity, got.raw, got.avg, got.height);
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [STATUS_W-1:0] status,
                            input logic [DATA_W-1:0] range_val);
        t_command c;
        c.cmd       = cmd;
        c.status    = status;
        c.range_val = range_val;
        command_q.push_back(c);
    endtask

    // block until every queued command has been answered, then let it settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (command_q.size() != 0 || s_axis_tvalid || reading_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_SENSOR_READY: cfg_ready = val[0];
            REG_MIN_VALID:    cfg_min   = val;
            REG_MAX_RANGE:    cfg_max   = val;
            REG_CALIBRATION:  cfg_cal   = val[CAL_W-1:0];
            REG_WINDOW_SIZE: begin
                // a new window size also empties the window
                cfg_wsize = val[WSIZE_W-1:0];
                empty_window();
            end
            REG_STALE_TICKS:  cfg_stale = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic ready, input logic [DATA_W-1:0] lo,
                                 input logic [DATA_W-1:0] hi, input logic [CAL_W-1:0] cal,
                                 input logic [WSIZE_W-1:0] wsize,
                                 input logic [DATA_W-1:0] stale);
        write_reg(REG_SENSOR_READY, {{(DATA_W-1){1'b0}}, ready});
        write_reg(REG_MIN_VALID, lo);
        write_reg(REG_MAX_RANGE, hi);
        write_reg(REG_CALIBRATION, {{(DATA_W-CAL_W){1'b0}}, cal});
        write_reg(REG_WINDOW_SIZE, {{(DATA_W-WSIZE_W){1'b0}}, wsize});
        write_reg(REG_STALE_TICKS, stale);
    endtask

    // mostly well-formed samples near the accepted range, plus ticks, bursts and noise
    task automatic queue_random(input int count);
        int                  r;
        logic [STATUS_W-1:0] st;
        logic [DATA_W-1:0]   d;
        int                  burst;
        int                  n;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 62) begin
                r = $urandom_range(99);
                st = (r < 6) ? NO_TARGET_LO : (r < 12) ? NO_TARGET_HI
                                                       : STATUS_W'($urandom_range(254, 1));
                r = $urandom_range(99);
                if (r < 72 && cfg_min <= cfg_max)
                    d = DATA_W'($urandom_range(cfg_max, cfg_min));
                else if (r < 77)
                    d = cfg_min;
                else if (r < 82)
                    d = cfg_max;
                else if (r < 86)
                    d = cfg_min - 1'b1;
                else if (r < 90)
                    d = cfg_max + 1'b1;
                else
                    d = DATA_W'($urandom);
                push_cmd(CMD_SAMPLE, st, d);
                n++;
            end else if (r < 88) begin
                push_cmd(CMD_TICK, STATUS_W'($urandom), DATA_W'($urandom));
                n++;
            end else if (r < 93) begin
                // tick burst to push the age past the threshold
                burst = $urandom_range(40, 1);
                repeat (burst) push_cmd(CMD_TICK, STATUS_W'($urandom), DATA_W'($urandom));
                n += burst;
            end else if (r < 97) begin
                push_cmd(CMD_CLEAR, STATUS_W'($urandom), DATA_W'($urandom));
                n++;
            end else begin
                push_cmd(CMD_UNUSED, STATUS_W'($urandom), DATA_W'($urandom));
                n++;
            end
        end
    endtask

    initial begin : stim_proc
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        // shadow reset values
        cfg_ready = 1'b0;
        cfg_min   = 16'd20;
        cfg_max   = 16'd4000;
        cfg_cal   = '0;
        cfg_wsize = 6'd5;
        cfg_stale = 16'd1000;
        empty_window();
        age  = 0;
        held = '0;
        held.validity = VAL_INVALID;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sensor not ready: every command reports invalid, the age still runs
        push_cmd(CMD_SAMPLE, 8'd5, 16'd1000);
        push_cmd(CMD_TICK, 8'd0, 16'd0);
        push_cmd(CMD_CLEAR, 8'd0, 16'd0);
        push_cmd(CMD_UNUSED, 8'd0, 16'd0);
        wait_idle();

        // ready, reset limits, uncalibrated: no-target codes and range edges
        write_reg(REG_SENSOR_READY, 16'd1);
        push_cmd(CMD_SAMPLE, NO_TARGET_LO, 16'd1000);
        push_cmd(CMD_SAMPLE, NO_TARGET_HI, 16'd1000);
        push_cmd(CMD_SAMPLE, 8'd7, 16'd19);
        push_cmd(CMD_SAMPLE, 8'd7, 16'd20);
        push_cmd(CMD_SAMPLE, 8'd200, 16'd4000);
        push_cmd(CMD_SAMPLE, 8'd1, 16'd4001);
        push_cmd(CMD_SAMPLE, 8'd254, 16'hFFFF);
        push_cmd(CMD_SAMPLE, 8'd9, 16'd1000);
        push_cmd(CMD_TICK, 8'd0, 16'd0);
        push_cmd(CMD_CLEAR, 8'd0, 16'd0);
        push_cmd(CMD_SAMPLE, 8'd9, 16'd500);
        push_cmd(CMD_UNUSED, 8'hFF, 16'hFFFF);
        wait_idle();

        // calibrated, short window, quick stale
        write_reg(REG_CALIBRATION, 16'd100);
        write_reg(REG_WINDOW_SIZE, 16'd2);
        write_reg(REG_STALE_TICKS, 16'd2);
        push_cmd(CMD_SAMPLE, 8'd3, 16'd3000);
        push_cmd(CMD_SAMPLE, 8'd3, 16'd100);
        push_cmd(CMD_SAMPLE, 8'd3, 16'd2000);
        repeat (3) push_cmd(CMD_TICK, 8'd0, 16'd0);
        push_cmd(CMD_SAMPLE, 8'd3, 16'd50);
        wait_idle();

        // random phases, the first ones at the register extremes
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: apply_setting(1'b1, 16'd20, 16'd4000, 11'd80, 6'd5, 16'd10);
                1: apply_setting(1'b1, 16'd0, 16'hFFFF, -11'sd1024, 6'd1, 16'd0);
                2: apply_setting(1'b1, 16'd300, 16'd600, 11'd1023, 6'd32, 16'hFFFF);
                3: apply_setting(1'b1, 16'd100, 16'd9000, -11'sd1, 6'd0, 16'd25);
                4: apply_setting(1'b1, 16'd1, 16'd2500, 11'd1, 6'd63, 16'd5);
                5: apply_setting(1'b0, 16'd20, 16'd4000, 11'd60, 6'd8, 16'd3);
                default: begin
                    lo = DATA_W'($urandom_range(3000));
                    // now and then a max no higher than the min, so at most one value is accepted
                    hi = ($urandom_range(99) < 85) ? DATA_W'($urandom_range(16'hFFFF, lo))
                                                   : DATA_W'($urandom_range(lo));
                    apply_setting($urandom_range(99) < 90, lo, hi, CAL_W'($urandom),
                                  WSIZE_W'($urandom), DATA_W'($urandom_range(60)));
                end
            endcase
            calm = (p == 3);
            queue_random(150);
            wait_idle();
        end
        calm = 1'b0;

        // full-scale stale threshold, the age keeps running while the sensor is off
        apply_setting(1'b1, 16'd20, 16'd4000, 11'd50, 6'd4, 16'hFFFF);
        push_cmd(CMD_SAMPLE, 8'd5, 16'd1500);
        repeat (20) push_cmd(CMD_TICK, STATUS_W'($urandom), DATA_W'($urandom));
        wait_idle();
        write_reg(REG_SENSOR_READY, 16'd0);
        push_cmd(CMD_TICK, 8'd0, 16'd0);
        wait_idle();
        // a threshold lowered under the running age goes stale on the next tick
        write_reg(REG_STALE_TICKS, 16'd20);
        write_reg(REG_SENSOR_READY, 16'd1);
        push_cmd(CMD_TICK, 8'd0, 16'd0);
        push_cmd(CMD_SAMPLE, 8'd5, 16'd2500);

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (err_count == 0 && reading_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog_proc
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
